// File: design/gfa_pkg.sv
// Shared types, constants and coefficient table for the gamma approximation unit.
package gfa_pkg;

    localparam int FRAC_BITS = 30;
    localparam int COEF_BITS = 40;
    localparam int NUM_COEF  = 18;
    localparam int NUM_STEPS = NUM_COEF - 1;

    localparam int X_W  = 32;
    localparam int G_W  = 61;
    localparam int T_W  = FRAC_BITS + 1;
    localparam int P_W  = COEF_BITS + 4;
    localparam int UP_W = COEF_BITS + 3;
    localparam int MH_W = UP_W - 20;
    localparam int ML_W = 20;
    localparam int PH_W = T_W + MH_W;
    localparam int PL_W = T_W + ML_W;
    localparam int TQ_SH = COEF_BITS - FRAC_BITS;

    localparam int S_LOW = 3 * FRAC_BITS - COEF_BITS;
    localparam int S_MID = 2 * FRAC_BITS - COEF_BITS;
    localparam int H_SH  = COEF_BITS - FRAC_BITS;
    localparam int N_W   = UP_W + S_LOW;
    localparam int NH_W  = N_W - G_W;
    localparam int D_W   = 2 * FRAC_BITS + 2;
    localparam int R_W   = D_W + 1;

    localparam int DIV_STEPS = G_W;
    // input reg, two per Horner step, prep stage and divider input reg, divider bits, output reg
    localparam int LATENCY = 1 + 2 * NUM_STEPS + 2 + DIV_STEPS + 1;

    localparam logic [X_W-1:0] X_ONE = X_W'(64'd1 << FRAC_BITS);
    localparam logic [X_W-1:0] X_TWO = X_W'(64'd2 << FRAC_BITS);
    localparam logic [X_W-1:0] X_MAX = X_W'(64'd3 << FRAC_BITS);
    localparam logic [G_W-1:0] GAMMA_MAX = '1;

    localparam longint unsigned FIVE_POW16 = 64'd152587890625;

    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_MID,
        SEL_HIGH
    } gfa_sel_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [T_W-1:0] t;
        gfa_sel_t       sel;
        logic           err;
    } gfa_side_t;

    typedef struct packed {
        logic err;
        logic sat;
    } gfa_dctl_t;

    typedef logic signed [P_W-1:0] coef_arr_t [NUM_COEF];

    // coefficients times 1e16
    localparam longint COEF_DEC [NUM_COEF] = '{
        64'sd10000000000000000, 64'sd4227843350984678, 64'sd4118403304263672,
        64'sd815769192502609, 64'sd742490106800904, -64'sd2669810333484,
        64'sd111540360240344, -64'sd28525821446197, 64'sd21036287024598,
        -64'sd9184843690991, 64'sd4874227944768, -64'sd2347204018919,
        64'sd1115339519666, -64'sd478747983834, 64'sd175102727179,
        -64'sd49203750904, 64'sd9199156407, -64'sd839940496
    };

    // round(n * 2^24 / 5^16), sign kept
    function automatic longint coef_q40(longint n);
        logic            neg;
        longint unsigned m;
        longint unsigned q1;
        longint unsigned r1;
        longint unsigned q;
        neg = n < 0;
        m   = neg ? 64'd0 - longint'(unsigned'(n)) : longint'(unsigned'(n));
        q1  = m / FIVE_POW16;
        r1  = m % FIVE_POW16;
        q   = (q1 << 24) + ((r1 << 24) + FIVE_POW16 / 2) / FIVE_POW16;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic coef_arr_t build_coefs();
        coef_arr_t c;
        for (int i = 0; i < NUM_COEF; i++) begin
            c[i] = P_W'(coef_q40(COEF_DEC[i]));
        end
        return c;
    endfunction

    localparam coef_arr_t COEF_Q40 = build_coefs();

endpackage

// File: design/gamma_function_approx_unit.sv
// Top level of the fixed-point gamma function unit on (0,3].
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------
//  input    | start, busy          | x_value
//  result   | done (one cycle)     | gamma_value, domain_error
//
// One word accepted every cycle; busy is never raised.
// Each result passes through the 17 Horner steps (two stages each) and the
// 61-stage bit-per-stage divider.
// Reset clears only the valid bits; words in flight are dropped.
// Results cannot be held off, so the pipeline never stalls.
module gamma_function_approx_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [gfa_pkg::X_W-1:0]   x_value,
    output logic                      done,
    output logic [gfa_pkg::G_W-1:0]   gamma_value,
    output logic                      domain_error
);
    import gfa_pkg::*;

    // input stage: clamp and range reduction
    logic           s0_valid_reg;
    gfa_side_t      s0_side_reg;
    gfa_side_t      s0_side_next;
    logic [X_W-1:0] x_c;

    always_comb begin
        x_c = (x_value > X_MAX) ? X_MAX : x_value;
        s0_side_next.x   = x_c;
        s0_side_next.err = (x_value == '0);
        if (x_c <= X_ONE) begin
            s0_side_next.sel = SEL_LOW;
            s0_side_next.t   = T_W'(x_c);
        end else if (x_c <= X_TWO) begin
            s0_side_next.sel = SEL_MID;
            s0_side_next.t   = T_W'(x_c - X_ONE);
        end else begin
            s0_side_next.sel = SEL_HIGH;
            s0_side_next.t   = T_W'(x_c - X_TWO);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
        end else begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk) begin
        s0_side_reg <= s0_side_next;
    end

    logic                  h_valid;
    gfa_side_t             h_side;
    logic signed [P_W-1:0] h_p;

    gfa_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_side   (s0_side_reg),
        .out_valid (h_valid),
        .out_side  (h_side),
        .out_p     (h_p)
    );

    // prep stage: numerator scaling and divisor choice
    logic            pr_valid_reg;
    logic [N_W-1:0]  pr_num_reg;
    logic [N_W-1:0]  pr_num_next;
    logic [D_W-1:0]  pr_den_reg;
    logic [D_W-1:0]  pr_den_next;
    logic            pr_err_reg;
    logic [UP_W-1:0] up;
    logic [63:0]     xx;

    always_comb begin
        up = h_p[P_W-1] ? '0 : h_p[UP_W-1:0];
        xx = 64'(h_side.x) * (64'(h_side.x) + 64'(X_ONE));
        unique case (h_side.sel)
            SEL_LOW: begin
                pr_num_next = N_W'(up) << S_LOW;
                pr_den_next = D_W'(xx);
            end
            SEL_MID: begin
                pr_num_next = N_W'(up) << S_MID;
                pr_den_next = D_W'(h_side.x);
            end
            SEL_HIGH: begin
                pr_num_next = N_W'(up >> H_SH);
                pr_den_next = D_W'(1);
            end
            default: begin
                pr_num_next = '0;
                pr_den_next = D_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pr_valid_reg <= 1'b0;
        end else begin
            pr_valid_reg <= h_valid;
        end
    end

    always_ff @(posedge clk) begin
        pr_num_reg <= pr_num_next;
        pr_den_reg <= pr_den_next;
        pr_err_reg <= h_side.err;
    end

    logic           d_valid;
    logic [G_W-1:0] d_quot;
    gfa_dctl_t      d_ctl;

    gfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_valid_reg),
        .in_num    (pr_num_reg),
        .in_den    (pr_den_reg),
        .in_err    (pr_err_reg),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_ctl   (d_ctl)
    );

    logic           done_reg;
    logic [G_W-1:0] gamma_reg;
    logic [G_W-1:0] gamma_next;
    logic           err_reg;

    always_comb begin
        priority if (d_ctl.err) begin
            gamma_next = '0;
        end else if (d_ctl.sat) begin
            gamma_next = GAMMA_MAX;
        end else begin
            gamma_next = d_quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk) begin
        gamma_reg <= gamma_next;
        err_reg   <= d_ctl.err;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign gamma_value  = gamma_reg;
    assign domain_error = err_reg;

endmodule

// File: design/gfa_horner.sv
// Pipelined Horner evaluation of the degree-17 polynomial, two stages per step.
module gfa_horner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  gfa_pkg::gfa_side_t                in_side,
    output logic                              out_valid,
    output gfa_pkg::gfa_side_t                out_side,
    output logic signed [gfa_pkg::P_W-1:0]    out_p
);
    import gfa_pkg::*;

    logic signed [P_W-1:0] p_in [NUM_STEPS+1];
    gfa_side_t             s_in [NUM_STEPS+1];
    logic                  v_in [NUM_STEPS+1];

    assign p_in[0] = COEF_Q40[NUM_COEF-1];
    assign s_in[0] = in_side;
    assign v_in[0] = in_valid;

    for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
        localparam int CI = NUM_COEF - 2 - j;

        logic [PH_W-1:0] hi_reg;
        logic [PL_W-1:0] lo_reg;
        logic            neg_reg;
        gfa_side_t       ms_reg;
        logic            mv_reg;
        logic signed [P_W-1:0] p_reg;
        gfa_side_t             as_reg;
        logic                  av_reg;

        logic [P_W-1:0]  mag;
        logic [63:0]     hi_w;
        logic [63:0]     lo_w;
        logic [63:0]     r_w;
        logic signed [P_W-1:0] r_s;
        logic signed [P_W-1:0] p_next;

        // magnitude split into a high and a low part for two narrow products
        assign mag = p_in[j][P_W-1] ? P_W'(-p_in[j]) : P_W'(p_in[j]);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                mv_reg <= 1'b0;
                av_reg <= 1'b0;
            end else begin
                mv_reg <= v_in[j];
                av_reg <= mv_reg;
            end
        end

        assign hi_w   = 64'(hi_reg) << TQ_SH;
        assign lo_w   = (64'(lo_reg) << TQ_SH) >> 20;
        assign r_w    = (hi_w + lo_w) >> 20;
        assign r_s    = signed'(r_w[P_W-1:0]);
        assign p_next = (neg_reg ? -r_s : r_s) + COEF_Q40[CI];

        always_ff @(posedge clk) begin
            hi_reg  <= s_in[j].t * mag[UP_W-1:ML_W];
            lo_reg  <= s_in[j].t * mag[ML_W-1:0];
            neg_reg <= p_in[j][P_W-1];
            ms_reg  <= s_in[j];
            p_reg   <= p_next;
            as_reg  <= ms_reg;
        end

        assign p_in[j+1] = p_reg;
        assign s_in[j+1] = as_reg;
        assign v_in[j+1] = av_reg;
    end

    assign out_valid = v_in[NUM_STEPS];
    assign out_side  = s_in[NUM_STEPS];
    assign out_p     = p_in[NUM_STEPS];

endmodule

// File: design/gfa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module gfa_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [gfa_pkg::N_W-1:0]    in_num,
    input  logic [gfa_pkg::D_W-1:0]    in_den,
    input  logic                       in_err,
    output logic                       out_valid,
    output logic [gfa_pkg::G_W-1:0]    out_quot,
    output gfa_pkg::gfa_dctl_t         out_ctl
);
    import gfa_pkg::*;

    logic [R_W-1:0] r_in [DIV_STEPS+1];
    logic [D_W-1:0] d_in [DIV_STEPS+1];
    logic [G_W-1:0] n_in [DIV_STEPS+1];
    logic [G_W-1:0] q_in [DIV_STEPS+1];
    gfa_dctl_t      c_in [DIV_STEPS+1];
    logic           v_in [DIV_STEPS+1];

    logic [R_W-1:0] r0_reg;
    logic [D_W-1:0] d0_reg;
    logic [G_W-1:0] n0_reg;
    gfa_dctl_t      c0_reg;
    gfa_dctl_t      c0_next;
    logic           v0_reg;

    // quotient overflows 61 bits exactly when the top part alone reaches the divisor
    always_comb begin
        c0_next.err = in_err;
        c0_next.sat = D_W'(in_num[N_W-1:G_W]) >= in_den;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
        end else begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        r0_reg <= R_W'(in_num[N_W-1:G_W]);
        d0_reg <= in_den;
        n0_reg <= in_num[G_W-1:0];
        c0_reg <= c0_next;
    end

    assign r_in[0] = r0_reg;
    assign d_in[0] = d0_reg;
    assign n_in[0] = n0_reg;
    assign q_in[0] = '0;
    assign c_in[0] = c0_reg;
    assign v_in[0] = v0_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_bit
        logic [R_W-1:0] r_reg;
        logic [D_W-1:0] d_reg;
        logic [G_W-1:0] n_reg;
        logic [G_W-1:0] q_reg;
        gfa_dctl_t      c_reg;
        logic           v_reg;
        logic [R_W-1:0] rs;
        logic           ge;

        assign rs = {r_in[k][R_W-2:0], n_in[k][G_W-1]};
        assign ge = rs >= R_W'(d_in[k]);

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                v_reg <= 1'b0;
            end else begin
                v_reg <= v_in[k];
            end
        end

        always_ff @(posedge clk) begin
            r_reg <= ge ? rs - R_W'(d_in[k]) : rs;
            d_reg <= d_in[k];
            n_reg <= {n_in[k][G_W-2:0], 1'b0};
            q_reg <= {q_in[k][G_W-2:0], ge};
            c_reg <= c_in[k];
        end

        assign r_in[k+1] = r_reg;
        assign d_in[k+1] = d_reg;
        assign n_in[k+1] = n_reg;
        assign q_in[k+1] = q_reg;
        assign c_in[k+1] = c_reg;
        assign v_in[k+1] = v_reg;
    end

    assign out_valid = v_in[DIV_STEPS];
    assign out_quot  = q_in[DIV_STEPS];
    assign out_ctl   = c_in[DIV_STEPS];

endmodule

// File: design/gfa_checker.sv
// Port-level checks for the gamma unit, bound to the top level.
module gfa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [gfa_pkg::X_W-1:0]   x_value,
    input logic                      done,
    input logic [gfa_pkg::G_W-1:0]   gamma_value,
    input logic                      domain_error
);
    import gfa_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_word_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted word gave no result");

    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && x_value == '0 |-> ##LATENCY (done && domain_error))
        else $error("zero argument without domain error");

    a_nonzero_ok: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && x_value != '0 |-> ##LATENCY !domain_error)
        else $error("spurious domain error");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && domain_error |-> gamma_value == '0)
        else $error("domain error with non-zero result");

endmodule

bind gamma_function_approx_unit gfa_checker u_gfa_checker (.*);
